### hw/rtl/mm3_pkg.sv
// Shared types, constants and helpers for the MurmurHash3 x86_32 block.
`default_nettype none

package mm3_pkg;

  // Mixing and finaliser constants
  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

  // Bytes in a full message word
  localparam logic [2:0] WORD_BYTES = 3'd4;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // What the back end does with an item
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_BLOCK,
    KIND_TAIL
  } item_kind_t;

  // Classified, scrambled item handed from front to back
  typedef struct packed {
    item_kind_t  kind;
    logic [31:0] k;
    logic [2:0]  count;
    logic        last;
  } mm3_item_t;

  // Rotate left by a fixed amount
  function automatic logic [31:0] rotl32(input logic [31:0] v, input int r);
    return (v << r) | (v >> (32 - r));
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mm3_front.sv
// Front end: accepts items, classifies them and scrambles the key in two multiply stages.
`default_nettype none

module mm3_front
  import mm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic        in_last_word,
  output logic             push_valid,
  input  wire logic        push_ready,
  output mm3_item_t        push_item
);

  logic        a_valid_r;
  logic [31:0] a_k_r;
  item_kind_t  a_kind_r;
  logic [2:0]  a_count_r;
  logic        a_last_r;

  logic        b_valid_r;
  mm3_item_t   b_item_r;

  logic        a_ready;
  logic        b_ready;
  logic [2:0]  count_cl;
  logic [31:0] mask;
  item_kind_t  kind;

  // Clamp the count, pick the byte mask and class
  always_comb begin
    count_cl = in_byte_count[2] ? WORD_BYTES : in_byte_count;
    case (count_cl)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    if (count_cl == WORD_BYTES) begin
      kind = KIND_BLOCK;
    end else if (count_cl == 3'd0) begin
      kind = KIND_NONE;
    end else begin
      kind = KIND_TAIL;
    end
  end

  // Stall control: a stage moves when the next one has room
  assign b_ready  = !b_valid_r || push_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  // Stage A: mask and first multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_k_r     <= (in_data_word & mask) * MIX_C1;
      a_kind_r  <= kind;
      a_count_r <= count_cl;
      a_last_r  <= in_last_word;
    end
  end

  // Stage B: rotate and second multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
    if (b_ready && a_valid_r) begin
      b_item_r.k     <= rotl32(a_k_r, 15) * MIX_C2;
      b_item_r.kind  <= a_kind_r;
      b_item_r.count <= a_count_r;
      b_item_r.last  <= a_last_r;
    end
  end

  assign push_valid = b_valid_r;
  assign push_item  = b_item_r;

endmodule

`default_nettype wire

### hw/rtl/mm3_queue.sv
// Short item queue that decouples the front end from the back end.
`default_nettype none

module mm3_queue
  import mm3_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire mm3_item_t push_item,
  output logic           pop_valid,
  input  wire logic      pop,
  output mm3_item_t      pop_item
);

  mm3_item_t          entry_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  fill_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer wrap at the depth
  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) wr_ptr_r <= bump(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
    if (do_push) entry_r[wr_ptr_r] <= push_item;
  end

endmodule

`default_nettype wire

### hw/rtl/mm3_back.sv
// Back end: running hash and length update, finaliser and result register.
`default_nettype none

module mm3_back
  import mm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        pop_valid,
  output logic             pop,
  input  wire mm3_item_t   pop_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_hash_value
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_MUL1,
    ST_MUL2,
    ST_SEND
  } state_t;

  state_t      state_r,    state_nxt;
  logic [31:0] hash_r,     hash_nxt;
  logic [31:0] len_r,      len_nxt;
  logic [31:0] fin_r,      fin_nxt;
  logic        out_vld_r,  out_vld_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic [31:0] hash_upd;
  logic [31:0] len_upd;
  logic [31:0] pre_fin;

  // Mix the popped item into the running hash
  always_comb begin
    case (pop_item.kind)
      KIND_BLOCK: hash_upd = (rotl32(hash_r ^ pop_item.k, 13) * 32'd5) + MIX_ADD;
      KIND_TAIL:  hash_upd = hash_r ^ pop_item.k;
      default:    hash_upd = hash_r;
    endcase
    len_upd = len_r + {29'd0, pop_item.count};
    pre_fin = hash_upd ^ len_upd;
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    hash_nxt     = hash_r;
    len_nxt      = len_r;
    fin_nxt      = fin_r;
    out_hash_nxt = out_hash_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    pop          = 1'b0;
    case (state_r)
      ST_RUN: begin
        if (pop_valid) begin
          pop = 1'b1;
          if (pop_item.last) begin
            fin_nxt   = pre_fin ^ (pre_fin >> 16);
            hash_nxt  = '0;
            len_nxt   = '0;
            state_nxt = ST_MUL1;
          end else begin
            hash_nxt = hash_upd;
            len_nxt  = len_upd;
          end
        end
      end
      ST_MUL1: begin
        fin_nxt   = fin_r * FIN_M1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        fin_nxt   = (fin_r ^ (fin_r >> 13)) * FIN_M2;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        // Load the result once the output register is free
        if (!out_vld_r || out_ready) begin
          out_hash_nxt = fin_r ^ (fin_r >> 16);
          out_vld_nxt  = 1'b1;
          state_nxt    = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      hash_r    <= '0;
      len_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      hash_r    <= hash_nxt;
      len_r     <= len_nxt;
      out_vld_r <= out_vld_nxt;
    end
    fin_r      <= fin_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_vld_r;
  assign out_hash_value = out_hash_r;

endmodule

`default_nettype wire

### hw/rtl/murmur3_hash32_top.sv
// Top level of the streaming MurmurHash3 x86_32 (seed zero) block.
`default_nettype none

// MurmurHash3 x86_32, seed zero, over a stream of little-endian 32-bit words
// (first byte in bits 7:0). Each item gives up to four bytes in byte_count;
// counts above four are taken as four and bytes above the count are ignored.
// The item with last_word set closes the message: one hash comes out for it
// and the state clears, so the next item starts a new message. An empty
// message hashes to 0. Items that are not last are taken one per cycle while
// the queue has room: the front end scrambles each key in two registered
// multiply stages, and the back end folds one queued item per cycle into the
// running hash. A last item holds the back end for the update, two finaliser
// multiply steps and the load of the result register, while the front end and
// the two-entry queue go on taking items. On its way to out_valid, a last item
// passes stages A and B, the queue and the states RUN, MUL1, MUL2 and SEND.

module murmur3_hash32_top
  import mm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic        in_last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_hash_value
);

  logic      push_valid;
  logic      push_ready;
  mm3_item_t push_item;
  logic      pop_valid;
  logic      pop;
  mm3_item_t pop_item;

  mm3_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last_word  (in_last_word),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  mm3_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  mm3_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop            (pop),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

endmodule

`default_nettype wire
